FILE: design/indexed_shift_array_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for indexed_shift_array_top
// Concurrent checks on the clock named clock, masked while reset is high.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_ARRAY_TOP_MACROS_SVH
`define INDEXED_SHIFT_ARRAY_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge
`define ISA_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("indexed_shift_array: check failed");
// Check that a condition in one cycle leads to another in the next cycle
`define ISA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("indexed_shift_array: sequence check failed");
`else
`define ISA_ASSERT_ALWAYS(label, cond)
`define ISA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Shared sizes, request and status codes, and controller command type.
// ----------------------------------------------------------------------------
package isa_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int POS_W  = 4;
   localparam int REQ_W  = 3;
   localparam int STAT_W = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_APPEND      = 3'd0,
      REQ_REMOVE_LAST = 3'd1,
      REQ_INSERT      = 3'd2,
      REQ_REMOVE_AT   = 3'd3,
      REQ_READ        = 3'd4
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_BADIDX = 2'd3
   } status_code_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the incoming item
      logic commit;    // execute the latched item and load the result register
   } isa_cmd_type;

endpackage

FILE: design/isa_if.sv
// ----------------------------------------------------------------------------
// isa_req_if / isa_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface isa_req_if;
   logic                           valid;
   logic                           ready;
   logic [isa_pkg::REQ_W-1:0]      req_type;
   logic [isa_pkg::POS_W-1:0]      position;
   logic signed [isa_pkg::WORD_W-1:0] word_in;

   modport source (output valid, output req_type, output position, output word_in,
                   input ready);
   modport sink   (input valid, input req_type, input position, input word_in,
                   output ready);
endinterface

interface isa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [isa_pkg::WORD_W-1:0] word_out;
   logic [isa_pkg::CNT_W-1:0]         element_count;
   logic                              is_full;
   logic                              is_empty;
   logic [isa_pkg::STAT_W-1:0]        status;

   modport source (output valid, output word_out, output element_count,
                   output is_full, output is_empty, output status, input ready);
   modport sink   (input valid, input word_out, input element_count,
                   input is_full, input is_empty, input status, output ready);
endinterface

FILE: design/indexed_shift_array_top.sv
// ----------------------------------------------------------------------------
// indexed_shift_array_top
// Ordered array of up to 16 signed words with append, remove, insert, remove
// at index and read requests, one result item per request item.
// ----------------------------------------------------------------------------
// Each request item is first latched; then every cell picks hold, load, shift
// up or shift down in parallel and the result is written to the output
// register. A new item is taken while the previous result still waits on the
// result channel; execution stalls only when that register is still full. No
// new item is taken until the latched one has been executed.
// Refused requests change nothing and report full, empty or bad index.
`include "indexed_shift_array_top_macros.svh"

module indexed_shift_array_top (
   input  logic       clock,
   input  logic       reset,
   isa_req_if.sink    req_if,
   isa_rsp_if.source  rsp_if
);

   localparam int CNT_W = isa_pkg::CNT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(isa_pkg::DEPTH);

   isa_pkg::isa_cmd_type cmd;
   logic                 rsp_full_match;
   logic                 rsp_empty_match;

   // Sequence items through the datapath
   isa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd)
   );

   // Array storage and result formation
   isa_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_type      (req_if.req_type),
      .position      (req_if.position),
      .word_in       (req_if.word_in),
      .word_out      (rsp_if.word_out),
      .element_count (rsp_if.element_count),
      .is_full       (rsp_if.is_full),
      .is_empty      (rsp_if.is_empty),
      .status        (rsp_if.status)
   );

   // Flags must agree with the reported count
   assign rsp_full_match  = (rsp_if.is_full == (rsp_if.element_count == FULL_COUNT));
   assign rsp_empty_match = (rsp_if.is_empty == (rsp_if.element_count == '0));

   // Checks
   `ISA_ASSERT_ALWAYS(a_no_capture_and_commit, !(cmd.capture && cmd.commit))
   `ISA_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_if.valid)
   `ISA_ASSERT_ALWAYS(a_count_in_range, !rsp_if.valid || (rsp_if.element_count <= FULL_COUNT))
   `ISA_ASSERT_ALWAYS(a_flags_match_count, !rsp_if.valid || (rsp_full_match && rsp_empty_match))

endmodule

FILE: design/isa_ctrl.sv
// ----------------------------------------------------------------------------
// isa_ctrl
// Two-state controller: take an item, then execute it into the result register.
// ----------------------------------------------------------------------------
module isa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output isa_pkg::isa_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Result register can take a new item when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result valid until taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/isa_datapath.sv
// ----------------------------------------------------------------------------
// isa_datapath
// Cell array with per-cell hold/shift/load select, count, request and result
// registers.
// ----------------------------------------------------------------------------
module isa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  isa_pkg::isa_cmd_type                cmd,
   input  logic [isa_pkg::REQ_W-1:0]           req_type,
   input  logic [isa_pkg::POS_W-1:0]           position,
   input  logic signed [isa_pkg::WORD_W-1:0]   word_in,
   output logic signed [isa_pkg::WORD_W-1:0]   word_out,
   output logic [isa_pkg::CNT_W-1:0]           element_count,
   output logic                                is_full,
   output logic                                is_empty,
   output logic [isa_pkg::STAT_W-1:0]          status
);

   localparam int DEPTH  = isa_pkg::DEPTH;
   localparam int CNT_W  = isa_pkg::CNT_W;
   localparam int IDX_W  = isa_pkg::IDX_W;
   localparam int WORD_W = isa_pkg::WORD_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Latched request
   logic [isa_pkg::REQ_W-1:0]  op_ff;
   logic [isa_pkg::POS_W-1:0]  pos_ff;
   logic [WORD_W-1:0]          word_ff;

   // Array state
   logic [WORD_W-1:0] cells_ff [DEPTH];
   logic [WORD_W-1:0] cells_in [DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;

   // Result register
   logic [WORD_W-1:0]          word_out_ff, word_out_in;
   logic [CNT_W-1:0]           count_out_ff;
   logic                       full_out_ff, empty_out_ff;
   isa_pkg::status_code_type   stat_ff, stat_in;

   logic             arr_full, arr_empty;
   logic [CNT_W-1:0] pos_ext, ins_pos;
   logic             stat_ok;
   logic             do_insert, do_remove_at, do_remove_last, do_read;

   // Capture the incoming item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_type;
         pos_ff  <= position;
         word_ff <= word_in;
      end
   end

   assign arr_full  = (count_ff == DEPTH_CNT);
   assign arr_empty = (count_ff == '0);
   assign pos_ext   = CNT_W'(pos_ff);
   // Append is an insert at the current count
   assign ins_pos   = (op_ff == isa_pkg::REQ_APPEND) ? count_ff : pos_ext;

   // Classify the request
   always_comb begin
      stat_in = isa_pkg::STAT_OK;
      case (op_ff) inside
         isa_pkg::REQ_APPEND: begin
            if (arr_full) stat_in = isa_pkg::STAT_FULL;
         end
         isa_pkg::REQ_REMOVE_LAST: begin
            if (arr_empty) stat_in = isa_pkg::STAT_EMPTY;
         end
         isa_pkg::REQ_INSERT: begin
            if (arr_full) begin
               stat_in = isa_pkg::STAT_FULL;
            end else if (pos_ext > count_ff) begin
               stat_in = isa_pkg::STAT_BADIDX;
            end
         end
         isa_pkg::REQ_REMOVE_AT, isa_pkg::REQ_READ: begin
            if (arr_empty) begin
               stat_in = isa_pkg::STAT_EMPTY;
            end else if (pos_ext >= count_ff) begin
               stat_in = isa_pkg::STAT_BADIDX;
            end
         end
         default: begin
            stat_in = isa_pkg::STAT_OK;
         end
      endcase
   end

   assign stat_ok        = (stat_in == isa_pkg::STAT_OK);
   assign do_insert      = stat_ok && ((op_ff == isa_pkg::REQ_APPEND) ||
                                       (op_ff == isa_pkg::REQ_INSERT));
   assign do_remove_last = stat_ok && (op_ff == isa_pkg::REQ_REMOVE_LAST);
   assign do_remove_at   = stat_ok && (op_ff == isa_pkg::REQ_REMOVE_AT);
   assign do_read        = stat_ok && (op_ff == isa_pkg::REQ_READ);

   // Per-cell select: hold, load, take lower neighbor, take upper neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX      = CNT_W'(i);
      localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(i + 1);
      always_comb begin
         cells_in[i] = cells_ff[i];
         if (do_insert) begin
            if (IDX == ins_pos) begin
               cells_in[i] = word_ff;
            end else if (IDX > ins_pos && IDX <= count_ff) begin
               if (i > 0) cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_remove_at) begin
            if (IDX >= pos_ext && IDX_NEXT < count_ff) begin
               if (i < DEPTH - 1) cells_in[i] = cells_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   // Cells carry no reset; advance only on commit
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int k = 0; k < DEPTH; k++) begin
            cells_ff[k] <= cells_in[k];
         end
      end
   end

   // Update the count
   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove_last || do_remove_at) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // Read word, zero unless a successful read
   assign word_out_in = do_read ? cells_ff[pos_ext[IDX_W-1:0]] : '0;

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         word_out_ff  <= word_out_in;
         count_out_ff <= count_in;
         full_out_ff  <= (count_in == DEPTH_CNT);
         empty_out_ff <= (count_in == '0);
         stat_ff      <= stat_in;
      end
   end

   assign word_out      = word_out_ff;
   assign element_count = count_out_ff;
   assign is_full       = full_out_ff;
   assign is_empty      = empty_out_ff;
   assign status        = stat_ff;

endmodule

FILE: verif/isa_array_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isa_array_checker
// Watches the request and result channels of the indexed shift array, keeps
// its own copy of the stored words and count, predicts the result of every
// accepted request item and compares each accepted result item against the
// oldest prediction. Reports the number of failures, the number of results
// still owed and the predicted element count.
// ----------------------------------------------------------------------------
module isa_array_checker (
   input  logic             clock,
   input  logic             reset,
   isa_req_if               req_mon,
   isa_rsp_if               rsp_mon,
   output int               fail_count,
   output int               owed_results,
   output int               model_fill
);

   localparam int DEPTH  = isa_pkg::DEPTH;
   localparam int CNT_W  = isa_pkg::CNT_W;
   localparam int WORD_W = isa_pkg::WORD_W;
   localparam int STAT_W = isa_pkg::STAT_W;
   localparam int REQ_W  = isa_pkg::REQ_W;
   localparam int POS_W  = isa_pkg::POS_W;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      logic [CNT_W-1:0]         count;
      logic                     full;
      logic                     empty;
      logic [STAT_W-1:0]        status;
   } array_result_type;

   logic signed [WORD_W-1:0] shadow_cells [DEPTH];
   int                       occupancy = 0;
   int                       mismatches = 0;
   int                       owed = 0;
   array_result_type         owed_queue [$];

   assign fail_count   = mismatches;
   assign owed_results = owed;
   assign model_fill   = occupancy;

   // Queue a prediction behind the ones already owed
   function automatic void owe_result(input array_result_type res);
      owed_queue = {owed_queue, res};
   endfunction

   // Apply one request to the shadow array and return the result it gives
   function automatic array_result_type apply_request(
      input logic [REQ_W-1:0]         code,
      input logic [POS_W-1:0]         pos,
      input logic signed [WORD_W-1:0] word);
      array_result_type res;
      int               i;
      int               at;
      res        = '0;
      res.status = isa_pkg::STAT_OK;
      at         = int'(pos);
      case (code)
         isa_pkg::REQ_APPEND: begin
            if (occupancy >= DEPTH) begin
               res.status = isa_pkg::STAT_FULL;
            end else begin
               shadow_cells[occupancy] = word;
               occupancy++;
            end
         end
         isa_pkg::REQ_REMOVE_LAST: begin
            if (occupancy == 0) res.status = isa_pkg::STAT_EMPTY;
            else occupancy--;
         end
         isa_pkg::REQ_INSERT: begin
            // full is checked before the index
            if (occupancy >= DEPTH) begin
               res.status = isa_pkg::STAT_FULL;
            end else if (at > occupancy) begin
               res.status = isa_pkg::STAT_BADIDX;
            end else begin
               for (i = occupancy; i > at; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[at] = word;
               occupancy++;
            end
         end
         isa_pkg::REQ_REMOVE_AT: begin
            // empty is checked before the index
            if (occupancy == 0) begin
               res.status = isa_pkg::STAT_EMPTY;
            end else if (at >= occupancy) begin
               res.status = isa_pkg::STAT_BADIDX;
            end else begin
               for (i = at + 1; i < occupancy; i++) shadow_cells[i-1] = shadow_cells[i];
               occupancy--;
            end
         end
         isa_pkg::REQ_READ: begin
            if (occupancy == 0) res.status = isa_pkg::STAT_EMPTY;
            else if (at >= occupancy) res.status = isa_pkg::STAT_BADIDX;
            else res.word = shadow_cells[at];
         end
         default: begin
            // unused codes leave everything as it is
         end
      endcase
      res.count = occupancy[CNT_W-1:0];
      res.full  = (occupancy == DEPTH);
      res.empty = (occupancy == 0);
      return res;
   endfunction

   // Compare results first, then predict: no item is answered at the edge
   // that accepts it
   always @(posedge clock) begin
      array_result_type want;
      array_result_type got;
      if (reset) begin
         occupancy = 0;
         owed_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{word: rsp_mon.word_out, count: rsp_mon.element_count,
                    full: rsp_mon.is_full, empty: rsp_mon.is_empty,
                    status: rsp_mon.status};
            if (owed_queue.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item: word %0d cnt %0d full %0b empty %0b st %0d",
                        $time, got.word, got.count, got.full, got.empty, got.status);
            end else begin
               want = owed_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: expected word %0d cnt %0d full %0b empty %0b st %0d",
                           $time, want.word, want.count, want.full, want.empty,
                           want.status);
                  $display("%0t: actual   word %0d cnt %0d full %0b empty %0b st %0d",
                           $time, got.word, got.count, got.full, got.empty, got.status);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            owe_result(apply_request(req_mon.req_type, req_mon.position,
                                     req_mon.word_in));
         end
      end
      owed = owed_queue.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for indexed_shift_array_top. Drives a short directed sequence
// over the empty, full and bad index cases, then random request items in
// three idling phases, with a long result stall and a drain pause in each.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH       = isa_pkg::DEPTH;
   localparam int REQ_W       = isa_pkg::REQ_W;
   localparam int POS_W       = isa_pkg::POS_W;
   localparam int WORD_W      = isa_pkg::WORD_W;
   localparam int PHASE_ITEMS = 430;
   // Request codes with no operation behind them
   localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

   logic clock;
   logic reset;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   recv_hold     = 0;
   int   grow_bias     = 50;
   int   fail_count;
   int   owed_results;
   int   model_fill;

   isa_req_if req_bus ();
   isa_rsp_if rsp_bus ();

   indexed_shift_array_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   isa_array_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .fail_count   (fail_count),
      .owed_results (owed_results),
      .model_fill   (model_fill)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up well past the slowest correct run
   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: random back-pressure, or a counted hold-off when asked
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            recv_hold--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offer one item from a falling edge and return at the falling edge after
   // it is taken
   task automatic send_item(input logic [REQ_W-1:0] code, input logic [POS_W-1:0] pos,
                            input logic signed [WORD_W-1:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= code;
      req_bus.position <= pos;
      req_bus.word_in  <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly well-formed requests around the current fill, some noise
   task automatic send_random_item();
      logic [REQ_W-1:0]         code;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] word;
      int                       roll;
      int                       top_pos;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         code = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      end else if (roll < 24) begin
         code = isa_pkg::REQ_READ;
      end else if ($urandom_range(0, 99) < grow_bias) begin
         code = $urandom_range(0, 1) ? isa_pkg::REQ_APPEND : isa_pkg::REQ_INSERT;
      end else begin
         code = $urandom_range(0, 1) ? isa_pkg::REQ_REMOVE_LAST : isa_pkg::REQ_REMOVE_AT;
      end
      top_pos = (code == isa_pkg::REQ_INSERT) ? model_fill : model_fill - 1;
      if (top_pos > 15) top_pos = 15;
      if (top_pos < 0 || $urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 15));
      else pos = POS_W'($urandom_range(0, top_pos));
      case ($urandom_range(0, 7))
         0: word = 32'sh8000_0000;
         1: word = 32'sh7fff_ffff;
         2: word = '0;
         3: word = -1;
         default: word = $urandom;
      endcase
      send_item(code, pos, word);
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = isa_pkg::REQ_APPEND;
      req_bus.position = '0;
      req_bus.word_in  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty refusals, index limits, extremes, unused code
      send_item(isa_pkg::REQ_READ, 4'd0, 32'sd0);
      send_item(isa_pkg::REQ_REMOVE_LAST, 4'd0, 32'sd0);
      send_item(isa_pkg::REQ_REMOVE_AT, 4'd15, 32'sd0);
      send_item(isa_pkg::REQ_INSERT, 4'd1, 32'sd5);
      send_item(isa_pkg::REQ_INSERT, 4'd0, 32'sh7fff_ffff);
      send_item(isa_pkg::REQ_APPEND, 4'd15, 32'sh8000_0000);
      send_item(isa_pkg::REQ_INSERT, 4'd2, -32'sd1);
      send_item(isa_pkg::REQ_READ, 4'd3, 32'sd0);
      send_item(isa_pkg::REQ_REMOVE_AT, 4'd3, 32'sd0);
      send_item(isa_pkg::REQ_READ, 4'd1, 32'sd0);
      send_item(isa_pkg::REQ_REMOVE_AT, 4'd0, 32'sd0);
      send_item(REQ_UNUSED_HI, 4'd15, -32'sd1);
      // Fill up, then refuse on full and work at the top index
      while (model_fill < DEPTH) send_item(isa_pkg::REQ_APPEND, POS_W'(model_fill), $urandom);
      send_item(isa_pkg::REQ_APPEND, 4'd0, 32'sd1);
      send_item(isa_pkg::REQ_INSERT, 4'd15, 32'sd2);
      send_item(isa_pkg::REQ_READ, 4'd15, 32'sd0);
      send_item(isa_pkg::REQ_REMOVE_AT, 4'd15, 32'sd0);

      // Random phases: sender idles little, then receiver idles little, then none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 8;  recv_idle_pct = 73; end
            1: begin send_idle_pct = 73; recv_idle_pct = 8;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0) grow_bias = 15 + 35 * $urandom_range(0, 2);
            // stall the result side long enough to back up the input
            if (n == 150) recv_hold = 120;
            // hold off until every owed result is back
            if (n == 300) begin
               req_bus.valid <= 1'b0;
               @(negedge clock);
               while (owed_results != 0) @(negedge clock);
            end
            send_random_item();
         end
      end
      req_bus.valid <= 1'b0;

      // Drain, then keep watching for stray results before the verdict
      while (owed_results != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && owed_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/isa_pkg.sv
design/isa_if.sv
design/isa_ctrl.sv
design/isa_datapath.sv
design/indexed_shift_array_top.sv
verif/isa_array_checker.sv
verif/testbench.sv
